// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
// Depends on nothing; taken in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/cvwm_pkg.sv
// Package for the valid-window 2D convolution block: sizes, codes, payload types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cvwm_pkg;

    localparam int IMAGE_WIDTH   = 64;
    localparam int IMAGE_HEIGHT  = 64;
    localparam int KERNEL_HEIGHT = 3;
    localparam int KERNEL_WIDTH  = 3;
    localparam int DATA_BITS     = 16;

    localparam int LB_ROWS  = KERNEL_HEIGHT - 1;
    localparam int COL_BITS = $clog2(IMAGE_WIDTH);
    localparam int ROW_BITS = $clog2(IMAGE_HEIGHT);

    typedef logic signed [15:0]          sample_t;
    typedef logic signed [DATA_BITS-1:0] acc_t;
    typedef logic [COL_BITS-1:0]         col_t;
    typedef logic [ROW_BITS-1:0]         row_t;

    typedef enum logic {
        CMD_LOAD_COEFF  = 1'b0,
        CMD_PUSH_SAMPLE = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t       command;
        logic [1:0] coeff_row;
        logic [1:0] coeff_col;
        sample_t    coeff_value;
        sample_t    sample;
    } in_t;

    typedef struct packed {
        sample_t    result;
        logic [5:0] out_row;
        logic [5:0] out_col;
        logic       frame_end;
    } out_t;

    // Line buffer control from the top level.
    typedef struct packed {
        logic adv;      // pipeline advances this cycle
        logic push;     // sample transaction accepted
        logic shift;    // sample in stage 1 moves into the window
        col_t rd_col;   // column of the accepted sample
        col_t wr_col;   // column of the sample in stage 1
    } lb_ctl_t;

    // Per-cell control.
    typedef struct packed {
        logic       adv;
        logic       shift;
        logic       coef_we;
        logic [1:0] coef_row;
        sample_t    coef_value;
    } cell_ctl_t;

    // Item travelling down the pipeline.
    typedef struct packed {
        in_t        item;
        col_t       col;
        logic       emit;
        logic [5:0] out_row;
        logic [5:0] out_col;
        logic       frame_end;
    } stage_t;

endpackage

// File: rtl/cvwm_line_buf.sv
// Line buffers for the previous KERNEL_HEIGHT-1 image rows, one memory per row.
// Depends on cvwm_pkg. Per-entry valid bits make unwritten entries read as zero.
`timescale 1ns / 1ps

module cvwm_line_buf import cvwm_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  lb_ctl_t ctl,
    input  sample_t push_sample,
    output sample_t rd_data [LB_ROWS]
);

    genvar k;
    generate
        for (k = 0; k < LB_ROWS; k++) begin : g_row
            sample_t                mem [IMAGE_WIDTH];
            logic [IMAGE_WIDTH-1:0] vld_reg;
            sample_t                rd_q_reg;
            logic                   rd_vld_reg;
            logic                   we;
            col_t                   wr_addr;
            sample_t                wr_data;

            // Bottom row takes the new sample; upper rows take the row below.
            if (k == LB_ROWS - 1) begin : g_tail
                assign we      = ctl.push;
                assign wr_addr = ctl.rd_col;
                assign wr_data = push_sample;
            end else begin : g_inner
                assign we      = ctl.shift;
                assign wr_addr = ctl.wr_col;
                assign wr_data = rd_data[k+1];
            end

            always_ff @(posedge aclk) begin
                if (we) begin
                    mem[wr_addr] <= wr_data;
                end
                if (ctl.adv) begin
                    rd_q_reg <= mem[ctl.rd_col];
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg    <= '0;
                    rd_vld_reg <= 1'b0;
                end else begin
                    if (we) begin
                        vld_reg[wr_addr] <= 1'b1;
                    end
                    if (ctl.adv) begin
                        rd_vld_reg <= vld_reg[ctl.rd_col];
                    end
                end
            end

            assign rd_data[k] = rd_vld_reg ? rd_q_reg : '0;
        end
    endgenerate

endmodule

// File: rtl/cvwm_cell.sv
// One window column cell: holds a column of samples and its kernel coefficients,
// multiplies them and sums the column. Depends on cvwm_pkg.
`timescale 1ns / 1ps

module cvwm_cell import cvwm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl,
    input  sample_t   col_in  [KERNEL_HEIGHT],
    output sample_t   col_out [KERNEL_HEIGHT],
    output acc_t      col_sum
);

    sample_t             win_reg  [KERNEL_HEIGHT];
    sample_t             coef_reg [KERNEL_HEIGHT];
    acc_t                prod_reg [KERNEL_HEIGHT];
    logic signed [31:0]  prod_full [KERNEL_HEIGHT];
    acc_t                col_sum_reg;
    acc_t                col_sum_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KERNEL_HEIGHT; i++) begin
                win_reg[i]  <= '0;
                coef_reg[i] <= '0;
            end
        end else begin
            if (ctl.shift) begin
                for (int i = 0; i < KERNEL_HEIGHT; i++) begin
                    win_reg[i] <= col_in[i];
                end
            end
            if (ctl.coef_we) begin
                for (int i = 0; i < KERNEL_HEIGHT; i++) begin
                    if (ctl.coef_row == 2'(i)) begin
                        coef_reg[i] <= ctl.coef_value;
                    end
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < KERNEL_HEIGHT; i++) begin
            prod_full[i] = win_reg[i] * coef_reg[i];
        end
    end

    // Sums wrap to DATA_BITS, so products keep only their low bits.
    always_comb begin
        col_sum_next = '0;
        for (int i = 0; i < KERNEL_HEIGHT; i++) begin
            col_sum_next = col_sum_next + prod_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            for (int i = 0; i < KERNEL_HEIGHT; i++) begin
                prod_reg[i] <= prod_full[i][DATA_BITS-1:0];
            end
            col_sum_reg <= col_sum_next;
        end
    end

    assign col_out = win_reg;
    assign col_sum = col_sum_reg;

endmodule

// File: rtl/conv2d_valid_window_mac.sv
// Streaming valid-region 2D cross-correlation (kernel not flipped).
//
// s_ channel: one transaction per command. CMD_LOAD_COEFF writes one kernel
// coefficient (out-of-range row or column is ignored) and gives no result;
// CMD_PUSH_SAMPLE pushes the next raster-order sample. m_ channel: one result
// for each sample that completes a full window, with its output row and
// column; frame_end marks the last one of a frame, after which the position
// counters wrap.
// Throughput: one transaction per cycle while the output is not stalled. A
// result is valid once its sample has passed the line buffer read, window
// shift, multiply and column sum, then the output register holding the total.
// The whole pipeline advances whenever the output register is empty or taken,
// so a stalled receiver holds every stage and s_ready drops until it drains.
// Reset (aresetn low, synchronous) zeroes the kernel, the window, the
// counters and the line buffer valid bits; no clearing pass is needed, and
// the block takes a transaction on the first cycle after reset.
// Depends on cvwm_pkg, cvwm_line_buf, cvwm_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module conv2d_valid_window_mac import cvwm_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_payload,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_payload
);

    localparam int PIPE_DEPTH = 4;

    logic                  adv;
    logic                  acc_sample;
    row_t                  row_cnt_reg, row_cnt_next;
    col_t                  col_cnt_reg, col_cnt_next;
    logic                  last_col, last_row;
    stage_t                st0;
    stage_t                st_reg [PIPE_DEPTH];
    logic [PIPE_DEPTH-1:0] p_vld_reg;
    logic                  p1_shift;
    logic                  p2_load;
    logic [KERNEL_WIDTH-1:0] coef_we;
    lb_ctl_t               lb_ctl;
    sample_t               lb_rd [LB_ROWS];
    sample_t               new_col [KERNEL_HEIGHT];
    sample_t               win_col [KERNEL_WIDTH][KERNEL_HEIGHT];
    acc_t                  col_sum [KERNEL_WIDTH];
    acc_t                  total;
    logic                  m_valid_reg, m_valid_next;
    out_t                  m_payload_reg, m_payload_next;

    assign adv        = !m_valid_reg || m_ready;
    assign s_ready    = adv;
    assign acc_sample = s_valid && adv && (s_payload.command == CMD_PUSH_SAMPLE);

    // Raster position of the next sample.
    assign last_col = (col_cnt_reg == COL_BITS'(IMAGE_WIDTH - 1));
    assign last_row = (row_cnt_reg == ROW_BITS'(IMAGE_HEIGHT - 1));

    always_comb begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        if (acc_sample) begin
            if (last_col) begin
                col_cnt_next = '0;
                row_cnt_next = last_row ? '0 : row_cnt_reg + 1'b1;
            end else begin
                col_cnt_next = col_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end else begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
        end
    end

    always_comb begin
        st0.item      = s_payload;
        st0.col       = col_cnt_reg;
        st0.emit      = (s_payload.command == CMD_PUSH_SAMPLE)
                     && (row_cnt_reg >= ROW_BITS'(KERNEL_HEIGHT - 1))
                     && (col_cnt_reg >= COL_BITS'(KERNEL_WIDTH - 1));
        st0.out_row   = 6'(row_cnt_reg - ROW_BITS'(KERNEL_HEIGHT - 1));
        st0.out_col   = 6'(col_cnt_reg - COL_BITS'(KERNEL_WIDTH - 1));
        st0.frame_end = last_row && last_col;
    end

    // Item pipeline: stage 1 shifts the window, stage 2 multiplies / loads
    // coefficients, stage 3 sums columns, stage 4 feeds the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= '0;
        end else if (adv) begin
            p_vld_reg <= {p_vld_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0] <= st0;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                st_reg[i] <= st_reg[i-1];
            end
        end
    end

    assign p1_shift = adv && p_vld_reg[0] && (st_reg[0].item.command == CMD_PUSH_SAMPLE);
    assign p2_load  = adv && p_vld_reg[1] && (st_reg[1].item.command == CMD_LOAD_COEFF)
                   && (int'(st_reg[1].item.coeff_row) < KERNEL_HEIGHT);

    always_comb begin
        lb_ctl.adv    = adv;
        lb_ctl.push   = acc_sample;
        lb_ctl.shift  = p1_shift;
        lb_ctl.rd_col = col_cnt_reg;
        lb_ctl.wr_col = st_reg[0].col;
    end

    cvwm_line_buf u_line_buf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (lb_ctl),
        .push_sample (s_payload.sample),
        .rd_data     (lb_rd)
    );

    // Oldest row on top, the new sample at the bottom.
    always_comb begin
        for (int k = 0; k < LB_ROWS; k++) begin
            new_col[k] = lb_rd[k];
        end
        new_col[KERNEL_HEIGHT-1] = st_reg[0].item.sample;
    end

    genvar j;
    generate
        for (j = 0; j < KERNEL_WIDTH; j++) begin : g_cell
            cell_ctl_t ctl;

            assign coef_we[j] = p2_load && (int'(st_reg[1].item.coeff_col) == j);

            always_comb begin
                ctl.adv        = adv;
                ctl.shift      = p1_shift;
                ctl.coef_we    = coef_we[j];
                ctl.coef_row   = st_reg[1].item.coeff_row;
                ctl.coef_value = st_reg[1].item.coeff_value;
            end

            if (j == KERNEL_WIDTH - 1) begin : g_head
                cvwm_cell u_cell (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .ctl     (ctl),
                    .col_in  (new_col),
                    .col_out (win_col[j]),
                    .col_sum (col_sum[j])
                );
            end else begin : g_body
                cvwm_cell u_cell (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .ctl     (ctl),
                    .col_in  (win_col[j+1]),
                    .col_out (win_col[j]),
                    .col_sum (col_sum[j])
                );
            end
        end
    endgenerate

    always_comb begin
        total = '0;
        for (int i = 0; i < KERNEL_WIDTH; i++) begin
            total = total + col_sum[i];
        end
    end

    always_comb begin
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        if (adv) begin
            m_valid_next             = p_vld_reg[PIPE_DEPTH-1] && st_reg[PIPE_DEPTH-1].emit;
            m_payload_next.result    = 16'(total);
            m_payload_next.out_row   = st_reg[PIPE_DEPTH-1].out_row;
            m_payload_next.out_col   = st_reg[PIPE_DEPTH-1].out_col;
            m_payload_next.frame_end = st_reg[PIPE_DEPTH-1].frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    `ASSERT_IMPLY(a_frame_end_pos, aclk, aresetn, m_valid_reg && m_payload_reg.frame_end, (m_payload_reg.out_row == 6'(IMAGE_HEIGHT - KERNEL_HEIGHT)) && (m_payload_reg.out_col == 6'(IMAGE_WIDTH - KERNEL_WIDTH)))
    `ASSERT_IMPLY(a_coef_one_cell, aclk, aresetn, 1'b1, $onehot0(coef_we))
    `ASSERT_NEXT(a_frame_wrap, aclk, aresetn, acc_sample && last_row && last_col, (row_cnt_reg == '0) && (col_cnt_reg == '0))

endmodule
